// ===== design/tct_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch contact tracker package
// Shared codes, field widths, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tct_pkg;

    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int COORD_W = 16;
    localparam int KIND_W  = 2;
    localparam int CID_W   = 4;
    localparam int CNT_W   = 4;

    localparam logic [OP_W-1:0] OP_FRAME_START = 2'd0;
    localparam logic [OP_W-1:0] OP_POINT       = 2'd1;
    localparam logic [OP_W-1:0] OP_FRAME_END   = 2'd2;

    localparam logic [KIND_W-1:0] EV_BEGIN = 2'd0;
    localparam logic [KIND_W-1:0] EV_MOVE  = 2'd1;
    localparam logic [KIND_W-1:0] EV_END   = 2'd2;

    localparam int STATUS_READY_BIT = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } tct_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_step;
    } tct_cmd_t;

    typedef struct packed {
        logic out_free;
        logic op_end;
        logic scan_done;
    } tct_status_t;

endpackage

// ===== design/touch_contact_tracker.sv =====
// ----------------------------------------------------------------------------
// Touch contact tracker
// Turns touch controller frame reports into begin, move and end events for
// up to SLOTS contacts. Items are taken one at a time: a frame start or a
// point record is captured, then handled in one execute step into the
// output register, and a frame end is captured, passes one dispatch state
// and then the slot walk, in which the controller walks the slots in order
// and emits an end event for each pressed slot that was not reported.
// Each execute and slot-walk step waits until the single output register
// is free, so a stalled output slows the block by the length of the stall.
// A new item is accepted while the last event still waits in the output
// register.
// ----------------------------------------------------------------------------
module touch_contact_tracker
    import tct_pkg::*;
#(
    parameter int SLOTS = 5
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    op,
    input  logic [BYTE_W-1:0]  status_byte,
    input  logic [BYTE_W-1:0]  point_id,
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  event_kind,
    output logic [CID_W-1:0]   contact_id,
    output logic [COORD_W-1:0] event_x,
    output logic [COORD_W-1:0] event_y,
    output logic               last_event
);

    tct_cmd_t    cmd;
    tct_status_t status;

    tct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tct_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .op          (op),
        .status_byte (status_byte),
        .point_id    (point_id),
        .point_x     (point_x),
        .point_y     (point_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .contact_id  (contact_id),
        .event_x     (event_x),
        .event_y     (event_y),
        .last_event  (last_event)
    );

endmodule

// ===== design/tct_ctrl.sv =====
// ----------------------------------------------------------------------------
// Touch contact tracker controller
// Sequences one item at a time: capture, then a single execute step for
// frame starts and point records, or a slot walk for frame ends.
// ----------------------------------------------------------------------------
module tct_ctrl
    import tct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tct_status_t status,
    output tct_cmd_t    cmd
);

    tct_state_t state_reg;
    tct_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.op_end)
                begin
                    state_next = ST_SCAN;
                end
                else if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (status.out_free && status.scan_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.exec      = 1'b0;
        cmd.scan_step = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = status.out_free && !status.op_end;
            end
            ST_SCAN:
            begin
                cmd.scan_step = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/tct_datapath.sv =====
// ----------------------------------------------------------------------------
// Touch contact tracker datapath
// Holds the captured item, the per-slot contact state, the frame bookkeeping
// and the output register.
// ----------------------------------------------------------------------------
module tct_datapath
    import tct_pkg::*;
#(
    parameter int SLOTS = 5
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tct_cmd_t           cmd,
    output tct_status_t        status,
    input  logic [OP_W-1:0]    op,
    input  logic [BYTE_W-1:0]  status_byte,
    input  logic [BYTE_W-1:0]  point_id,
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  event_kind,
    output logic [CID_W-1:0]   contact_id,
    output logic [COORD_W-1:0] event_x,
    output logic [COORD_W-1:0] event_y,
    output logic               last_event
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [OP_W-1:0]    op_reg;
    logic [BYTE_W-1:0]  stat_reg;
    logic [BYTE_W-1:0]  id_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;

    logic [COORD_W-1:0] slot_x_reg [SLOTS];
    logic [COORD_W-1:0] slot_y_reg [SLOTS];
    logic [SLOTS-1:0]   pressed_reg;
    logic [SLOTS-1:0]   seen_reg;
    logic               accepting_reg;
    logic [CNT_W-1:0]   left_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic               out_valid_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [CID_W-1:0]   cid_reg;
    logic [COORD_W-1:0] ex_reg;
    logic [COORD_W-1:0] ey_reg;
    logic               last_reg;

    logic               out_free;
    logic [IDX_W-1:0]   rd_idx;
    logic [COORD_W-1:0] rd_x;
    logic [COORD_W-1:0] rd_y;
    logic [SLOTS-1:0]   pending;
    logic [CNT_W-1:0]   count;
    logic               frame_ok;
    logic               rec_take;
    logic               id_ok;
    logic               pos_diff;
    logic               scan_hit;
    logic               scan_last;

    assign out_free = !out_valid_reg || out_ready;
    assign rd_idx   = (op_reg == OP_FRAME_END) ? idx_reg : id_reg[IDX_W-1:0];
    assign rd_x     = slot_x_reg[rd_idx];
    assign rd_y     = slot_y_reg[rd_idx];
    assign pending  = pressed_reg & ~seen_reg;

    assign count    = stat_reg[CNT_W-1:0];
    assign frame_ok = stat_reg[STATUS_READY_BIT] && (count != '0)
                      && (count <= CNT_W'(SLOTS));
    assign rec_take = accepting_reg && (left_reg != '0);
    assign id_ok    = id_reg < BYTE_W'(SLOTS);
    assign pos_diff = (rd_x != x_reg) || (rd_y != y_reg);

    assign scan_hit  = pending[idx_reg];
    assign scan_last = ((pending >> idx_reg) >> 1) == '0;

    assign status.out_free  = out_free;
    assign status.op_end    = op_reg == OP_FRAME_END;
    assign status.scan_done = idx_reg == IDX_W'(SLOTS - 1);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            stat_reg <= status_byte;
            id_reg   <= point_id;
            x_reg    <= point_x;
            y_reg    <= point_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_x_reg[i] <= '0;
                slot_y_reg[i] <= '0;
            end
            pressed_reg   <= '0;
            seen_reg      <= '0;
            accepting_reg <= 1'b0;
            left_reg      <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            if (cmd.exec && (op_reg == OP_FRAME_START))
            begin
                seen_reg      <= '0;
                accepting_reg <= frame_ok;
                left_reg      <= frame_ok ? count : '0;
            end
            if (cmd.exec && (op_reg == OP_POINT) && rec_take)
            begin
                left_reg <= left_reg - 1'b1;
                if (id_ok)
                begin
                    seen_reg[rd_idx]   <= 1'b1;
                    slot_x_reg[rd_idx] <= x_reg;
                    slot_y_reg[rd_idx] <= y_reg;
                    if (pos_diff)
                    begin
                        pressed_reg[rd_idx] <= 1'b1;
                    end
                end
            end
            if (cmd.scan_step)
            begin
                idx_reg       <= idx_reg + 1'b1;
                accepting_reg <= 1'b0;
                left_reg      <= '0;
                if (scan_hit)
                begin
                    pressed_reg[idx_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec && (op_reg == OP_POINT) && rec_take && id_ok && pos_diff)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (cmd.scan_step && scan_hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && (op_reg == OP_POINT) && rec_take && id_ok && pos_diff)
        begin
            kind_reg <= pressed_reg[rd_idx] ? EV_MOVE : EV_BEGIN;
            cid_reg  <= id_reg[CID_W-1:0];
            ex_reg   <= x_reg;
            ey_reg   <= y_reg;
            last_reg <= 1'b1;
        end
        else if (cmd.scan_step && scan_hit)
        begin
            kind_reg <= EV_END;
            cid_reg  <= CID_W'(idx_reg);
            ex_reg   <= rd_x;
            ey_reg   <= rd_y;
            last_reg <= scan_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign contact_id = cid_reg;
    assign event_x    = ex_reg;
    assign event_y    = ey_reg;
    assign last_event = last_reg;

endmodule

// ===== test/touch_contact_tracker_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch contact tracker testbench
// Drives frame starts, point records and frame ends into the tracker and
// checks every begin, move and end event against an in-bench model of the
// slot state. A short table of directed reports comes first, followed by
// random frames with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module touch_contact_tracker_test;
    import tct_pkg::*;

    localparam int SLOTS          = 5;
    localparam int RANDOM_ITEMS   = 330;
    localparam int NUM_DIRECTED   = 27;
    localparam int HOLD_AT        = 120;
    localparam int HOLD_CYCLES    = 300;
    localparam int QUIET_FROM     = 220;
    localparam int QUIET_TO       = 300;
    localparam int DRAIN_CYCLES   = 4 * (SLOTS + 2);
    localparam int EMPTY_LIMIT    = 20000;
    localparam int TIMEOUT_NS     = 2000000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [BYTE_W-1:0]  status;
        logic [BYTE_W-1:0]  id;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } touch_report_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CID_W-1:0]   cid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } contact_event_t;

    typedef struct packed {
        touch_report_t  item;
        logic           typed;
        logic           has_ev;
        contact_event_t ev;
    } report_row_t;

    localparam contact_event_t NO_EVENT = '0;

    // Rows marked typed carry their expected event; the rest use the model.
    localparam report_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{OP_FRAME_END,   8'h00, 8'h00, 16'h0000, 16'h0000}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_POINT,       8'h00, 8'h01, 16'h1234, 16'h5678}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_UNUSED,      8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_FRAME_START, 8'h85, 8'h00, 16'h0000, 16'h0000}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_POINT,       8'h00, 8'h00, 16'hFFFF, 16'hFFFF}, 1'b1, 1'b1,
          '{EV_BEGIN, 4'd0, 16'hFFFF, 16'hFFFF, 1'b1}},
        '{'{OP_POINT,       8'h00, 8'h04, 16'h0000, 16'h0000}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_POINT,       8'h00, 8'h04, 16'h0001, 16'h0000}, 1'b1, 1'b1,
          '{EV_BEGIN, 4'd4, 16'h0001, 16'h0000, 1'b1}},
        '{'{OP_POINT,       8'h00, 8'hFF, 16'h4321, 16'h8765}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_POINT,       8'h00, 8'h05, 16'h4321, 16'h8765}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_POINT,       8'h00, 8'h01, 16'h0005, 16'h0005}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_FRAME_END,   8'h00, 8'h00, 16'h0000, 16'h0000}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_FRAME_START, 8'h82, 8'h00, 16'h0000, 16'h0000}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_POINT,       8'h00, 8'h00, 16'hFFFF, 16'h0000}, 1'b1, 1'b1,
          '{EV_MOVE, 4'd0, 16'hFFFF, 16'h0000, 1'b1}},
        '{'{OP_FRAME_END,   8'h00, 8'h00, 16'h0000, 16'h0000}, 1'b1, 1'b1,
          '{EV_END, 4'd4, 16'h0001, 16'h0000, 1'b1}},
        '{'{OP_FRAME_START, 8'h05, 8'h00, 16'h0000, 16'h0000}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_FRAME_END,   8'h00, 8'h00, 16'h0000, 16'h0000}, 1'b1, 1'b1,
          '{EV_END, 4'd0, 16'hFFFF, 16'h0000, 1'b1}},
        '{'{OP_FRAME_START, 8'h80, 8'h00, 16'h0000, 16'h0000}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_FRAME_START, 8'h86, 8'h00, 16'h0000, 16'h0000}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_POINT,       8'h00, 8'h02, 16'h0222, 16'h0333}, 1'b1, 1'b0, NO_EVENT},
        '{'{OP_FRAME_START, 8'hF5, 8'hAA, 16'h5555, 16'hAAAA}, 1'b0, 1'b0, NO_EVENT},
        '{'{OP_POINT,       8'h7F, 8'h04, 16'h8004, 16'h7FFB}, 1'b0, 1'b0, NO_EVENT},
        '{'{OP_POINT,       8'h00, 8'h03, 16'h8003, 16'h7FFC}, 1'b0, 1'b0, NO_EVENT},
        '{'{OP_POINT,       8'h00, 8'h02, 16'h8002, 16'h7FFD}, 1'b0, 1'b0, NO_EVENT},
        '{'{OP_POINT,       8'h00, 8'h01, 16'h8001, 16'h7FFE}, 1'b0, 1'b0, NO_EVENT},
        '{'{OP_POINT,       8'h00, 8'h00, 16'h8000, 16'h7FFF}, 1'b0, 1'b0, NO_EVENT},
        '{'{OP_FRAME_START, 8'h00, 8'h00, 16'h0000, 16'h0000}, 1'b0, 1'b0, NO_EVENT},
        '{'{OP_FRAME_END,   8'hFF, 8'h00, 16'h0000, 16'h0000}, 1'b0, 1'b0, NO_EVENT}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    op = '0;
    logic [BYTE_W-1:0]  status_byte = '0;
    logic [BYTE_W-1:0]  point_id = '0;
    logic [COORD_W-1:0] point_x = '0;
    logic [COORD_W-1:0] point_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [KIND_W-1:0]  event_kind;
    logic [CID_W-1:0]   contact_id;
    logic [COORD_W-1:0] event_x;
    logic [COORD_W-1:0] event_y;
    logic               last_event;

    logic [COORD_W-1:0] slot_pos_x [SLOTS] = '{default: '0};
    logic [COORD_W-1:0] slot_pos_y [SLOTS] = '{default: '0};
    logic [SLOTS-1:0]   slot_down = '0;
    logic [SLOTS-1:0]   slot_reported = '0;
    logic               frame_open = 1'b0;
    logic [CNT_W-1:0]   records_open = '0;

    contact_event_t pending_events [$];
    int mismatches = 0;
    int items_sent = 0;
    int items_effective = 0;
    int frames_taken = 0;
    int frames_rejected = 0;
    int records_used = 0;
    int kind_seen [3] = '{0, 0, 0};
    bit hold_done = 1'b0;
    int hold_left = 0;

    touch_contact_tracker #(
        .SLOTS(SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .status_byte(status_byte),
        .point_id(point_id),
        .point_x(point_x),
        .point_y(point_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .event_kind(event_kind),
        .contact_id(contact_id),
        .event_x(event_x),
        .event_y(event_y),
        .last_event(last_event)
    );

    always #4 clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d events still expected.", pending_events.size());
        $display("touch_contact_tracker_test: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic track_report(input touch_report_t r, input bit queue_it);
        contact_event_t   evs [$];
        logic [CNT_W-1:0] count;
        count = r.status[CNT_W-1:0];
        case (r.op)
            OP_FRAME_START:
            begin
                items_effective++;
                slot_reported = '0;
                if (r.status[STATUS_READY_BIT] && count >= 1 && count <= SLOTS)
                begin
                    frame_open = 1'b1;
                    records_open = count;
                    frames_taken++;
                end
                else
                begin
                    frame_open = 1'b0;
                    records_open = '0;
                    frames_rejected++;
                end
            end
            OP_POINT:
            begin
                if (frame_open && records_open > 0)
                begin
                    items_effective++;
                    records_used++;
                    records_open = records_open - 1'b1;
                    if (r.id < SLOTS)
                    begin
                        slot_reported[r.id] = 1'b1;
                        if (slot_pos_x[r.id] != r.x || slot_pos_y[r.id] != r.y)
                        begin
                            evs.push_back('{slot_down[r.id] ? EV_MOVE : EV_BEGIN,
                                            r.id[CID_W-1:0], r.x, r.y, 1'b0});
                            slot_down[r.id] = 1'b1;
                        end
                        slot_pos_x[r.id] = r.x;
                        slot_pos_y[r.id] = r.y;
                    end
                end
            end
            OP_FRAME_END:
            begin
                items_effective++;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_down[i] && !slot_reported[i])
                    begin
                        evs.push_back('{EV_END, CID_W'(i), slot_pos_x[i], slot_pos_y[i], 1'b0});
                        slot_down[i] = 1'b0;
                    end
                end
                frame_open = 1'b0;
                records_open = '0;
            end
            default:
            begin
            end
        endcase
        if (evs.size() > 0)
            evs[evs.size() - 1].last = 1'b1;
        if (queue_it)
            foreach (evs[i])
                pending_events.push_back(evs[i]);
    endtask

    task automatic send_report(input touch_report_t r, input bit queue_it);
        while (!(items_sent >= QUIET_FROM && items_sent < QUIET_TO) && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= r.op;
        status_byte <= r.status;
        point_id <= r.id;
        point_x <= r.x;
        point_y <= r.y;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        track_report(r, queue_it);
    endtask

    task automatic send_point(input logic [BYTE_W-1:0] id);
        touch_report_t r;
        int            mode;
        mode = $urandom_range(0, 9);
        r.op = OP_POINT;
        r.status = 8'($urandom);
        r.id = id;
        if (mode < 3 && id < SLOTS)
        begin
            r.x = slot_pos_x[id];
            r.y = slot_pos_y[id];
        end
        else if (mode < 7)
        begin
            r.x = 16'($urandom_range(0, 3)) * 16'h5555;
            r.y = 16'($urandom_range(0, 3)) * 16'h5555;
        end
        else
        begin
            r.x = 16'($urandom);
            r.y = 16'($urandom);
        end
        send_report(r, 1'b1);
    endtask

    // Receiver side: random stalls, one long hold-off and a stall-free stretch.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (rst_n && !hold_done && items_sent >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (items_sent >= QUIET_FROM && items_sent < QUIET_TO)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 8);
    end

    always @(posedge clk)
    begin
        contact_event_t got;
        contact_event_t want;
        got = '{event_kind, contact_id, event_x, event_y, last_event};
        if (rst_n && out_valid && out_ready)
        begin
            if (got.kind <= EV_END)
                kind_seen[got.kind]++;
            if (pending_events.size() == 0)
                report_mismatch($sformatf("unexpected transfer kind %0d id %0d x %h y %h last %0d",
                                          got.kind, got.cid, got.x, got.y, got.last));
            else
            begin
                want = pending_events.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "expected kind %0d id %0d x %h y %h last %0d, got %0d %0d %h %h %0d",
                        want.kind, want.cid, want.x, want.y, want.last,
                        got.kind, got.cid, got.x, got.y, got.last));
            end
        end
    end

    initial
    begin
        touch_report_t r;
        int            count;
        int            mode;
        int            waited;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < NUM_DIRECTED; n++)
        begin
            send_report(DIRECTED_ROWS[n].item, !DIRECTED_ROWS[n].typed);
            if (DIRECTED_ROWS[n].typed && DIRECTED_ROWS[n].has_ev)
                pending_events.push_back(DIRECTED_ROWS[n].ev);
        end

        items_effective = 0;
        while (items_effective < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 99);
            if (mode < 75)
            begin
                count = $urandom_range(1, SLOTS);
                r = '{OP_FRAME_START, {1'b1, 3'($urandom), 4'(count)}, 8'($urandom),
                      16'($urandom), 16'($urandom)};
                send_report(r, 1'b1);
                for (int k = 0; k < count; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_point(8'($urandom_range(SLOTS, 255)));
                    else
                        send_point(8'($urandom_range(0, SLOTS - 1)));
                end
                if ($urandom_range(0, 9) == 0)
                    send_point(8'($urandom));
                if ($urandom_range(0, 19) != 0)
                begin
                    r = '{OP_FRAME_END, 8'($urandom), 8'($urandom), 16'($urandom),
                          16'($urandom)};
                    send_report(r, 1'b1);
                end
            end
            else if (mode < 88)
            begin
                r = '{2'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom)};
                send_report(r, 1'b1);
            end
            else
            begin
                r = '{OP_FRAME_START, 8'($urandom), 8'($urandom), 16'($urandom),
                      16'($urandom)};
                send_report(r, 1'b1);
                count = $urandom_range(0, 3);
                for (int k = 0; k < count; k++)
                    send_point(8'($urandom_range(0, SLOTS)));
                r = '{OP_FRAME_END, 8'($urandom), 8'($urandom), 16'($urandom),
                      16'($urandom)};
                send_report(r, 1'b1);
            end
        end
        in_valid <= 1'b0;

        waited = 0;
        while (pending_events.size() != 0 && waited < EMPTY_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_events.size() != 0)
            report_mismatch($sformatf("%0d expected events never arrived",
                                      pending_events.size()));

        $display("Sent %0d reports: %0d frames taken, %0d rejected, %0d point records used.",
                 items_sent, frames_taken, frames_rejected, records_used);
        $display("Checked %0d begin, %0d move and %0d end transfers, %0d mismatches.",
                 kind_seen[EV_BEGIN], kind_seen[EV_MOVE], kind_seen[EV_END], mismatches);
        if (mismatches == 0)
            $display("touch_contact_tracker_test: PASS");
        else
            $display("touch_contact_tracker_test: FAIL");
        $finish;
    end

endmodule
